// ===== hw/rtl/mpe_pkg.sv =====
// Shared types and constants for the parenthesized-expression extremum block.
// Used by mpe_ctrl, mpe_dp and the top level; depends on nothing else.
package mpe_pkg;

    localparam int VALUE_W = 16;
    localparam int OP_W    = 2;
    localparam int DATA_W  = 64;
    localparam int HALF_W  = DATA_W / 2;

    // Operator codes; the unused code behaves as plus.
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    // Partial product selects for the shared 32x32 multiplier.
    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;

    localparam logic signed [DATA_W-1:0] EXT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] EXT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       init_ext;
        logic       mul_en;
        logic [1:0] mul_ph;
        logic       acc_ld;
        logic       acc_add;
        logic       upd;
        logic       use_mul;
        logic [1:0] sel;
        logic       wb;
        logic       out_ld;
        logic       out_err;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_sts;

endpackage

// ===== hw/rtl/mpe_dp.sv =====
// Datapath: range tables, operator store, shared multiplier and extremum tracking.
// Depends on mpe_pkg; driven by commands from mpe_ctrl.
module mpe_dp #(
    parameter int MAX_OPERANDS = 16
) (
    input  logic                                    i_clk,
    input  mpe_pkg::t_dp_cmd                        i_cmd,
    output mpe_pkg::t_dp_sts                        o_sts,
    input  logic [$clog2(MAX_OPERANDS)-1:0]         i_idx_i,
    input  logic [$clog2(MAX_OPERANDS)-1:0]         i_idx_k,
    input  logic [$clog2(MAX_OPERANDS)-1:0]         i_idx_j,
    input  logic [mpe_pkg::VALUE_W-1:0]             i_value,
    input  logic [mpe_pkg::OP_W-1:0]                i_op,
    output logic signed [mpe_pkg::DATA_W-1:0]       o_max_result,
    output logic signed [mpe_pkg::DATA_W-1:0]       o_min_result,
    output logic                                    o_error
);
    import mpe_pkg::*;

    localparam int IW    = $clog2(MAX_OPERANDS);
    localparam int DEPTH = MAX_OPERANDS * MAX_OPERANDS;
    localparam int AW    = $clog2(DEPTH);

    // Each table entry holds {max, min} of one subrange.
    logic [2*DATA_W-1:0] r_tab [DEPTH];
    logic [OP_W-1:0]     r_ops [MAX_OPERANDS];

    logic [2*DATA_W-1:0]      r_rd_a;
    logic [2*DATA_W-1:0]      r_rd_b;
    logic [OP_W-1:0]          r_op;
    logic [DATA_W-1:0]        r_prod;
    logic [DATA_W-1:0]        r_acc;
    logic signed [DATA_W-1:0] r_lo;
    logic signed [DATA_W-1:0] r_hi;
    logic signed [DATA_W-1:0] r_max;
    logic signed [DATA_W-1:0] r_min;
    logic                     r_err;

    logic [IW-1:0]            w_k1;
    logic [AW-1:0]            w_addr_a;
    logic [AW-1:0]            w_addr_b;
    logic [AW-1:0]            w_addr_w;
    logic [DATA_W-1:0]        w_a;
    logic [DATA_W-1:0]        w_b;
    logic [HALF_W-1:0]        w_mx;
    logic [HALF_W-1:0]        w_my;
    logic [DATA_W-1:0]        w_diag;
    logic signed [DATA_W-1:0] w_cand;

    assign w_k1     = i_idx_k + IW'(1);
    assign w_addr_a = AW'(i_idx_i) * AW'(MAX_OPERANDS) + AW'(i_idx_k);
    assign w_addr_b = AW'(w_k1) * AW'(MAX_OPERANDS) + AW'(i_idx_j);
    assign w_addr_w = AW'(i_idx_i) * AW'(MAX_OPERANDS) + AW'(i_idx_j);

    assign w_a = i_cmd.sel[1] ? r_rd_a[DATA_W-1:0] : r_rd_a[2*DATA_W-1:DATA_W];
    assign w_b = i_cmd.sel[0] ? r_rd_b[DATA_W-1:0] : r_rd_b[2*DATA_W-1:DATA_W];

    assign w_mx   = (i_cmd.mul_ph == PP_HL) ? w_a[DATA_W-1:HALF_W] : w_a[HALF_W-1:0];
    assign w_my   = (i_cmd.mul_ph == PP_LH) ? w_b[DATA_W-1:HALF_W] : w_b[HALF_W-1:0];
    assign w_diag = DATA_W'(i_value);

    always_comb begin
        if (i_cmd.use_mul) begin
            w_cand = r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end else if (r_op == OP_SUB) begin
            w_cand = w_a - w_b;
        end else begin
            w_cand = w_a + w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tab[w_addr_w] <= {w_diag, w_diag};
            r_ops[i_idx_k]  <= i_op;
        end else if (i_cmd.wb) begin
            r_tab[w_addr_w] <= {r_hi, r_lo};
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_tab[w_addr_a];
            r_rd_b <= r_tab[w_addr_b];
            r_op   <= r_ops[i_idx_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_mx * w_my;
        end
        if (i_cmd.acc_ld) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        if (i_cmd.init_ext) begin
            r_lo <= EXT_MAX;
            r_hi <= EXT_MIN;
        end else if (i_cmd.upd) begin
            if (w_cand < r_lo) begin
                r_lo <= w_cand;
            end
            if (w_cand > r_hi) begin
                r_hi <= w_cand;
            end
        end
        if (i_cmd.out_ld) begin
            r_err <= i_cmd.out_err;
            r_max <= i_cmd.out_err ? '0 : r_rd_a[2*DATA_W-1:DATA_W];
            r_min <= i_cmd.out_err ? '0 : r_rd_a[DATA_W-1:0];
        end
    end

    assign o_sts.op     = r_op;
    assign o_max_result = r_max;
    assign o_min_result = r_min;
    assign o_error      = r_err;

endmodule

// ===== hw/rtl/mpe_ctrl.sv =====
// Controller: operand loading, interval loop sequencing and output handshake.
// Depends on mpe_pkg; commands mpe_dp through a t_dp_cmd struct.
module mpe_ctrl #(
    parameter int MAX_OPERANDS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mpe_pkg::t_dp_cmd                    o_cmd,
    input  mpe_pkg::t_dp_sts                    i_sts,
    output logic [$clog2(MAX_OPERANDS)-1:0]     o_idx_i,
    output logic [$clog2(MAX_OPERANDS)-1:0]     o_idx_k,
    output logic [$clog2(MAX_OPERANDS)-1:0]     o_idx_j
);
    import mpe_pkg::*;

    localparam int IW = $clog2(MAX_OPERANDS);
    localparam int CW = $clog2(MAX_OPERANDS + 1);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_RANGE  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_OPER   = 3'd3;
    localparam logic [2:0] S_WB     = 3'd4;
    localparam logic [2:0] S_FIN_RD = 3'd5;
    localparam logic [2:0] S_FIN_LD = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_n, n_n;
    logic          r_err, n_err;
    logic [CW-1:0] r_s, n_s;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_k, n_k;
    logic [1:0]    r_t, n_t;
    logic [1:0]    r_ph, n_ph;
    logic          r_out_vld, n_out_vld;

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_full;
    logic [CW-1:0] w_j;
    logic          w_mul;

    assign o_stall   = (r_state != S_LOAD);
    assign o_valid   = r_out_vld;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_vld && !i_stall;
    assign w_full    = (r_cnt == CW'(MAX_OPERANDS));
    assign w_j       = CW'(r_i) + r_s;
    assign w_mul     = (i_sts.op == OP_MUL);

    always_comb begin
        o_idx_i = r_i;
        o_idx_k = r_k;
        o_idx_j = w_j[IW-1:0];
        unique case (r_state)
            S_LOAD: begin
                o_idx_i = r_cnt[IW-1:0];
                o_idx_k = r_cnt[IW-1:0];
                o_idx_j = r_cnt[IW-1:0];
            end
            S_FIN_RD: begin
                o_idx_i = '0;
                o_idx_k = IW'(r_n - CW'(1));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_n       = r_n;
        n_err     = r_err;
        n_s       = r_s;
        n_i       = r_i;
        n_k       = r_k;
        n_t       = r_t;
        n_ph      = r_ph;
        n_out_vld = r_out_vld && !w_out_acc;
        o_cmd     = '0;
        o_cmd.sel = r_t;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (!w_full) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_n   = w_full ? r_cnt : r_cnt + CW'(1);
                        n_err = r_ovf || w_full;
                        n_cnt = '0;
                        n_ovf = 1'b0;
                        n_s   = CW'(1);
                        n_i   = '0;
                        n_state = (r_ovf || w_full) ? S_FIN_LD : S_RANGE;
                    end
                end
            end
            S_RANGE: begin
                if (r_s >= r_n) begin
                    n_state = S_FIN_RD;
                end else begin
                    o_cmd.init_ext = 1'b1;
                    n_k     = r_i;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_t      = '0;
                n_ph     = '0;
                n_state  = S_OPER;
            end
            S_OPER: begin
                if (w_mul && r_ph != 2'd3) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_ph  = (r_ph == 2'd0) ? PP_LL : (r_ph == 2'd1) ? PP_LH : PP_HL;
                    o_cmd.acc_ld  = (r_ph == 2'd1);
                    o_cmd.acc_add = (r_ph == 2'd2);
                    n_ph          = r_ph + 2'd1;
                end else begin
                    o_cmd.upd     = 1'b1;
                    o_cmd.use_mul = w_mul;
                    n_ph          = '0;
                    n_t           = r_t + 2'd1;
                    if (r_t == 2'd3) begin
                        if (CW'(r_k) + CW'(1) == w_j) begin
                            n_state = S_WB;
                        end else begin
                            n_k     = r_k + IW'(1);
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (w_j + CW'(1) < r_n) begin
                    n_i = r_i + IW'(1);
                end else begin
                    n_i = '0;
                    n_s = r_s + CW'(1);
                end
                n_state = S_RANGE;
            end
            S_FIN_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FIN_LD;
            end
            S_FIN_LD: begin
                if (!r_out_vld || w_out_acc) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_err = r_err;
                    n_out_vld     = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_n       <= '0;
            r_err     <= 1'b0;
            r_s       <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_t       <= '0;
            r_ph      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
            r_n       <= n_n;
            r_err     <= n_err;
            r_s       <= n_s;
            r_i       <= n_i;
            r_k       <= n_k;
            r_t       <= n_t;
            r_ph      <= n_ph;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ===== hw/rtl/max_parenthesized_expression.sv =====
// Operands are taken one per cycle; the final operand starts the interval program.
// Per subrange a setup state and a write-back state; per split a read state plus four candidate
// steps, each a single update for plus and minus, or low-low, low-high and high-low partial
// products then the update for times. o_valid rises once the full range is read and loaded;
// a single operand skips the loop, an over-capacity one also the read; a stalled result delays it.
// Reset is synchronous and active low and clears control state; the range tables are not cleared.
module max_parenthesized_expression #(
    parameter int MAX_OPERANDS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mpe_pkg::VALUE_W-1:0]         i_value,
    input  logic [mpe_pkg::OP_W-1:0]            i_op,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mpe_pkg::DATA_W-1:0]   o_max_result,
    output logic signed [mpe_pkg::DATA_W-1:0]   o_min_result,
    output logic                                o_error
);
    import mpe_pkg::*;

    localparam int IW = $clog2(MAX_OPERANDS);

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [IW-1:0] w_idx_i;
    logic [IW-1:0] w_idx_k;
    logic [IW-1:0] w_idx_j;

    mpe_ctrl #(
        .MAX_OPERANDS(MAX_OPERANDS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_last  (i_last),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts),
        .o_idx_i (w_idx_i),
        .o_idx_k (w_idx_k),
        .o_idx_j (w_idx_j)
    );

    mpe_dp #(
        .MAX_OPERANDS(MAX_OPERANDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_idx_i      (w_idx_i),
        .i_idx_k      (w_idx_k),
        .i_idx_j      (w_idx_j),
        .i_value      (i_value),
        .i_op         (i_op),
        .o_max_result (o_max_result),
        .o_min_result (o_min_result),
        .o_error      (o_error)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_max_result == '0 && o_min_result == '0)
        else $error("Error result carries nonzero values.");

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> o_max_result >= o_min_result)
        else $error("Maximum result is below minimum result.");

    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("Result appeared without a preceding computation.");

endmodule
